>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Types, sizes and helpers of the set-associative cache lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int MAX_SETS = 256;
   localparam int MAX_WAYS = 16;
   localparam int SET_W    = $clog2(MAX_SETS);
   localparam int WAY_W    = $clog2(MAX_WAYS);
   localparam int CNT_W    = WAY_W + 1;
   localparam int AGE_W    = WAY_W;
   localparam int TAG_W    = 32;

   localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
   localparam logic [2:0] REG_SET_BITS    = 3'd1;
   localparam logic [2:0] REG_WAYS        = 3'd2;
   localparam logic [2:0] REG_REPLACE_LRU = 3'd3;
   localparam logic [2:0] REG_WRITE_BACK  = 3'd4;

   typedef struct packed {
      logic [WAY_W-1:0]                fifo;
      logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
      logic [MAX_WAYS-1:0]             dirty;
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
   } set_row_type;

   typedef struct packed {
      logic match;
      logic empty;
      logic older;
   } cmp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

>>> hdl/sacl_way_cmp.sv
// ----------------------------------------------------------------------------
// sacl_way_cmp
// Shared per-way compare unit: tag match, empty way and age ordering.
// ----------------------------------------------------------------------------
module sacl_way_cmp (
   input  logic [sacl_pkg::TAG_W-1:0] way_tag,
   input  logic                       way_valid,
   input  logic [sacl_pkg::AGE_W-1:0] way_age,
   input  logic [sacl_pkg::TAG_W-1:0] key_tag,
   input  logic [sacl_pkg::AGE_W-1:0] best_age,
   output sacl_pkg::cmp_type          result
);
   assign result.match = way_valid && (way_tag == key_tag);
   assign result.empty = !way_valid;
   assign result.older = way_age > best_age;
endmodule

>>> hdl/sacl_tag_store.sv
// ----------------------------------------------------------------------------
// sacl_tag_store
// One row per set: tags, valid, dirty, ages and FIFO pointer. Per-row valid
// flops make a never-written row read back as cleared.
// ----------------------------------------------------------------------------
module sacl_tag_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [sacl_pkg::SET_W-1:0]  rd_set,
   input  logic                        wr_en,
   input  logic [sacl_pkg::SET_W-1:0]  wr_set,
   input  sacl_pkg::set_row_type       wr_row,
   output sacl_pkg::set_row_type       rd_row
);
   sacl_pkg::set_row_type mem [sacl_pkg::MAX_SETS];
   sacl_pkg::set_row_type rd_data_ff;
   logic [sacl_pkg::MAX_SETS-1:0] row_ok_ff;
   logic rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_set] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
         rd_ok_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_ok_ff[wr_set] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= row_ok_ff[rd_set];
         end
      end
   end

   always_comb begin
      rd_row = rd_data_ff;
      if (!rd_ok_ff) begin
         rd_row.fifo  = '0;
         rd_row.age   = '0;
         rd_row.dirty = '0;
         rd_row.valid = '0;
      end
   end
endmodule

>>> hdl/set_assoc_cache_lookup_top.sv
// Sequence: ADDR reads the set row, SCAN checks one way per cycle through the shared
// compare unit, UPD writes the row back, and OUT holds the result until it is taken.
// A new access is accepted only once the result has been taken.
// Reset: synchronous; tag store rows read as cleared until written, no clearing
// pass; registers return to offset 2, sets 0, ways 1, FIFO, write-through.
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_top
// Set-associative cache tag lookup with FIFO/LRU replacement, WT/WB policy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_cache_lookup_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // address
   input  logic         req_tuser,   // is_write
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, mem_read, mem_write, hits_total, misses_total, reads_total,
   // writes_total, zero pad
   output logic [135:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int WW = sacl_pkg::WAY_W;
   localparam int CW = sacl_pkg::CNT_W;
   localparam int AW = sacl_pkg::AGE_W;

   typedef enum logic [2:0] {ST_IDLE, ST_ADDR, ST_SCAN, ST_UPD, ST_OUT} state_type;

   // configuration
   logic [4:0] off_ff;
   logic [3:0] sets_ff;
   logic [4:0] ways_ff;
   logic       lru_ff;
   logic       wb_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= 5'd2;
         sets_ff <= 4'd0;
         ways_ff <= 5'd1;
         lru_ff  <= 1'b0;
         wb_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            sacl_pkg::REG_OFFSET_BITS: off_ff  <= csr_pwdata[4:0];
            sacl_pkg::REG_SET_BITS:    sets_ff <= csr_pwdata[3:0];
            sacl_pkg::REG_WAYS:        ways_ff <= csr_pwdata[4:0];
            sacl_pkg::REG_REPLACE_LRU: lru_ff  <= csr_pwdata[0];
            sacl_pkg::REG_WRITE_BACK:  wb_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         sacl_pkg::REG_OFFSET_BITS: csr_prdata = {27'd0, off_ff};
         sacl_pkg::REG_SET_BITS:    csr_prdata = {28'd0, sets_ff};
         sacl_pkg::REG_WAYS:        csr_prdata = {27'd0, ways_ff};
         sacl_pkg::REG_REPLACE_LRU: csr_prdata = {31'd0, lru_ff};
         sacl_pkg::REG_WRITE_BACK:  csr_prdata = {31'd0, wb_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // effective settings
   logic [4:0] ob_eff;
   logic [3:0] sb_eff;
   logic [CW-1:0] ways_eff;
   logic [5:0] tag_shift;
   logic [31:0] set_mask;
   logic [sacl_pkg::SET_W-1:0] set_calc;
   logic [31:0] tag_calc;

   assign ob_eff   = (off_ff > 5'd16) ? 5'd16 : off_ff;
   assign sb_eff   = (sets_ff > 4'd8) ? 4'd8 : sets_ff;
   assign ways_eff = (ways_ff == 5'd0) ? CW'(1) :
                     (ways_ff > CW'(sacl_pkg::MAX_WAYS)) ? CW'(sacl_pkg::MAX_WAYS) :
                     CW'(ways_ff);
   assign tag_shift = {1'b0, ob_eff} + {2'b0, sb_eff};
   assign set_mask  = (32'd1 << sb_eff) - 32'd1;

   // sequencer registers
   state_type state_ff, state_in;
   logic [31:0] addr_ff, addr_in;
   logic        wr_ff, wr_in;
   logic [31:0] tag_ff, tag_in;
   logic [sacl_pkg::SET_W-1:0] set_ff, set_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        hitf_ff, hitf_in;
   logic [WW-1:0] hitw_ff, hitw_in;
   logic        invf_ff, invf_in;
   logic [WW-1:0] invw_ff, invw_in;
   logic [AW-1:0] best_ff, best_in;
   logic [WW-1:0] lruw_ff, lruw_in;
   logic [31:0] hits_ff, hits_in, miss_ff, miss_in, rd_ff, rd_in, wrc_ff, wrc_in;
   logic [135:0] out_ff, out_in;

   assign set_calc = sacl_pkg::SET_W'((addr_ff >> ob_eff) & set_mask);
   assign tag_calc = addr_ff >> tag_shift;

   // tag store
   sacl_pkg::set_row_type rd_row, new_row;
   logic mem_rd, mem_wr;

   assign mem_rd = (state_ff == ST_ADDR);
   assign mem_wr = (state_ff == ST_UPD);

   sacl_tag_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (mem_rd),
      .rd_set (set_calc),
      .wr_en  (mem_wr),
      .wr_set (set_ff),
      .wr_row (new_row),
      .rd_row (rd_row)
   );

   // shared compare unit
   logic [WW-1:0] scan_idx;
   sacl_pkg::cmp_type cmp;

   assign scan_idx = cnt_ff[WW-1:0];

   sacl_way_cmp u_cmp (
      .way_tag   (rd_row.tag[scan_idx]),
      .way_valid (rd_row.valid[scan_idx]),
      .way_age   (rd_row.age[scan_idx]),
      .key_tag   (tag_ff),
      .best_age  (best_ff),
      .result    (cmp)
   );

   // update of the set row
   logic [WW-1:0] vic, fifo_v, fifo_nx;
   logic          full_miss, mwrite, mread;
   logic [WW:0]   old_age;

   always_comb begin
      full_miss = !hitf_ff && !invf_ff;
      fifo_v  = ({1'b0, rd_row.fifo} < ways_eff) ? rd_row.fifo : '0;
      fifo_nx = ({1'b0, fifo_v} + CW'(1) >= ways_eff) ? '0 : fifo_v + WW'(1);
      if (hitf_ff) begin
         vic = hitw_ff;
      end else if (invf_ff) begin
         vic = invw_ff;
      end else if (lru_ff) begin
         vic = lruw_ff;
      end else begin
         vic = fifo_v;
      end
      old_age = rd_row.valid[vic] ? {1'b0, rd_row.age[vic]} : (WW+1)'(sacl_pkg::MAX_WAYS);
      new_row = rd_row;
      for (int v = 0; v < sacl_pkg::MAX_WAYS; v++) begin
         if ((CW'(v) < ways_eff) && (WW'(v) != vic) && rd_row.valid[v] &&
             ({1'b0, rd_row.age[v]} < old_age) && (rd_row.age[v] != {AW{1'b1}})) begin
            new_row.age[v] = rd_row.age[v] + AW'(1);
         end
      end
      new_row.age[vic] = '0;
      mread = !hitf_ff;
      if (hitf_ff) begin
         new_row.dirty[vic] = rd_row.dirty[vic] || (wr_ff && wb_ff);
         mwrite = wr_ff && !wb_ff;
      end else begin
         new_row.tag[vic]   = tag_ff;
         new_row.valid[vic] = 1'b1;
         new_row.dirty[vic] = wr_ff && wb_ff;
         if (full_miss && !lru_ff) begin
            new_row.fifo = fifo_nx;
         end
         mwrite = (wr_ff && !wb_ff) || (full_miss && wb_ff && rd_row.dirty[vic]);
      end
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;  wr_in = wr_ff;  tag_in = tag_ff;  set_in = set_ff;
      cnt_in = cnt_ff;    hitf_in = hitf_ff;  hitw_in = hitw_ff;
      invf_in = invf_ff;  invw_in = invw_ff;  best_in = best_ff;  lruw_in = lruw_ff;
      hits_in = hits_ff;  miss_in = miss_ff;  rd_in = rd_ff;  wrc_in = wrc_ff;
      out_in = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               addr_in  = req_tdata;
               wr_in    = req_tuser;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            tag_in  = tag_calc;
            set_in  = set_calc;
            cnt_in  = '0;
            hitf_in = 1'b0;
            invf_in = 1'b0;
            best_in = '0;
            lruw_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!hitf_ff && cmp.match) begin
               hitf_in = 1'b1;
               hitw_in = scan_idx;
            end
            if (!invf_ff && cmp.empty) begin
               invf_in = 1'b1;
               invw_in = scan_idx;
            end
            if (cmp.older) begin
               best_in = rd_row.age[scan_idx];
               lruw_in = scan_idx;
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == ways_eff - CW'(1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            hits_in = hitf_ff ? sacl_pkg::sat_inc(hits_ff) : hits_ff;
            miss_in = hitf_ff ? miss_ff : sacl_pkg::sat_inc(miss_ff);
            rd_in   = mread ? sacl_pkg::sat_inc(rd_ff) : rd_ff;
            wrc_in  = mwrite ? sacl_pkg::sat_inc(wrc_ff) : wrc_ff;
            out_in  = {5'd0, wrc_in, rd_in, miss_in, hits_in, mwrite, mread, hitf_ff};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hits_ff  <= '0;
         miss_ff  <= '0;
         rd_ff    <= '0;
         wrc_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         rd_ff    <= rd_in;
         wrc_ff   <= wrc_in;
         cnt_ff   <= cnt_in;
      end
      addr_ff <= addr_in;  wr_ff <= wr_in;  tag_ff <= tag_in;  set_ff <= set_in;
      hitf_ff <= hitf_in;  hitw_ff <= hitw_in;  invf_ff <= invf_in;  invw_ff <= invw_in;
      best_ff <= best_in;  lruw_ff <= lruw_in;  out_ff <= out_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = out_ff;

   `ASSERT_IMPLIES(a_no_overlap, rsp_tvalid, !req_tready, "ready while result pending")
   `ASSERT_IMPLIES(a_read_on_miss, rsp_tvalid, rsp_tdata[1] != rsp_tdata[0], "fill read must match miss")
   `ASSERT_IMPLIES(a_scan_bound, state_ff == ST_SCAN, cnt_ff < ways_eff, "scan beyond ways")
   `ASSERT_NEXT(a_upd_to_out, state_ff == ST_UPD, rsp_tvalid, "result not presented")
endmodule
